// ----- sv/b2s_pkg.sv -----
// b2s_pkg: constants, types and helper functions for the BLAKE2s hash engine.
// No dependencies.
`default_nettype none
package b2s_pkg;

    localparam int unsigned NUM_REGS = 6;
    localparam int unsigned CFG_W = 64;
    localparam int unsigned IDX_W = 3;
    localparam int unsigned BEAT_W = 36;

    localparam logic [IDX_W-1:0] REG_DIGEST_BYTES = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_BYTES    = 3'd1;
    localparam logic [IDX_W-1:0] REG_KEY_WORD_0   = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY_WORD_1   = 3'd3;
    localparam logic [IDX_W-1:0] REG_KEY_WORD_2   = 3'd4;
    localparam logic [IDX_W-1:0] REG_KEY_WORD_3   = 3'd5;

    localparam logic [31:0] PARAM_BASE = 32'h0101_0000;
    localparam logic [31:0] LAST_FLAG  = 32'hFFFF_FFFF;

    typedef logic [31:0] word_t;

    function automatic word_t iv_word(input logic [2:0] i);
        word_t r;
        unique case (i)
            3'd0: r = 32'h6A09E667;
            3'd1: r = 32'hBB67AE85;
            3'd2: r = 32'h3C6EF372;
            3'd3: r = 32'hA54FF53A;
            3'd4: r = 32'h510E527F;
            3'd5: r = 32'h9B05688C;
            3'd6: r = 32'h1F83D9AB;
            default: r = 32'h5BE0CD19;
        endcase
        return r;
    endfunction

    // message schedule: word index for round r, slot s
    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
        logic [63:0] row;
        unique case (r)
            4'd0: row = 64'hFEDCBA9876543210;
            4'd1: row = 64'h357B20C16DF984AE;
            4'd2: row = 64'h491763EADF250C8B;
            4'd3: row = 64'h8F04A562EBCD1397;
            4'd4: row = 64'hD386CB1EFA427509;
            4'd5: row = 64'h91EF57D438B0A6C2;
            4'd6: row = 64'hB8293670A4DEF15C;
            4'd7: row = 64'hA2684F05931CE7BD;
            4'd8: row = 64'h5A417D2C803B9EF6;
            default: row = 64'h0DC3E9BF5167482A;
        endcase
        return row[{s, 2'b00} +: 4];
    endfunction

    // byte mask for n valid bytes (n >= 4 -> all)
    function automatic word_t byte_mask(input logic [6:0] n);
        word_t r;
        priority if (n >= 7'd4) r = 32'hFFFF_FFFF;
        else if (n == 7'd3)     r = 32'h00FF_FFFF;
        else if (n == 7'd2)     r = 32'h0000_FFFF;
        else if (n == 7'd1)     r = 32'h0000_00FF;
        else                    r = 32'h0;
        return r;
    endfunction

    typedef struct packed {
        logic        start;
        logic        last;
        logic [63:0] counter;
    } cmp_req_t;

endpackage
`default_nettype wire

// ----- sv/b2s_stream_if.sv -----
// b2s_stream_if: valid/ready channel carrying one beat of payload.
// Depends on b2s_pkg.
`default_nettype none
interface b2s_stream_if (input wire logic clk);
    logic                        valid;
    logic                        ready;
    logic [b2s_pkg::BEAT_W-1:0]  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/b2s_compress.sv -----
// b2s_compress: BLAKE2s compression with one shared G unit, one half-G per cycle.
// Depends on b2s_pkg.
`default_nettype none
module b2s_compress (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire b2s_pkg::cmp_req_t req,
    input  wire b2s_pkg::word_t    cv_in  [8],
    input  wire b2s_pkg::word_t    msg    [16],
    output b2s_pkg::word_t         cv_out [8],
    output logic                   done
);
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;
    state_t state_reg;
    logic [3:0] round_reg;
    logic [2:0] g_reg;
    logic       half_reg;
    b2s_pkg::word_t v_reg [16];

    logic [3:0] ia, ib, ic, id;
    logic [3:0] mi;
    b2s_pkg::word_t a, b, c, d, m, a1, d1, c1, b1;

    always_comb
    begin
        unique case (g_reg)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        mi = b2s_pkg::sigma(round_reg, {g_reg, half_reg});
        m  = msg[mi];
        a  = v_reg[ia];
        b  = v_reg[ib];
        c  = v_reg[ic];
        d  = v_reg[id];
        a1 = a + b + m;
        d1 = half_reg ? {(d ^ a1) >> 8} | {(d ^ a1) << 24}
                      : {(d ^ a1) >> 16} | {(d ^ a1) << 16};
        c1 = c + d1;
        b1 = half_reg ? {(b ^ c1) >> 7} | {(b ^ c1) << 25}
                      : {(b ^ c1) >> 12} | {(b ^ c1) << 20};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            g_reg     <= '0;
            half_reg  <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.start)
                    begin
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= cv_in[i];
                        for (int i = 0; i < 4; i++)
                            v_reg[i+8] <= b2s_pkg::iv_word(3'(i));
                        v_reg[12] <= b2s_pkg::iv_word(3'd4) ^ req.counter[31:0];
                        v_reg[13] <= b2s_pkg::iv_word(3'd5) ^ req.counter[63:32];
                        v_reg[14] <= b2s_pkg::iv_word(3'd6) ^
                                     (req.last ? b2s_pkg::LAST_FLAG : 32'h0);
                        v_reg[15] <= b2s_pkg::iv_word(3'd7);
                        round_reg <= '0;
                        g_reg     <= '0;
                        half_reg  <= 1'b0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    v_reg[ia] <= a1;
                    v_reg[ib] <= b1;
                    v_reg[ic] <= c1;
                    v_reg[id] <= d1;
                    half_reg  <= ~half_reg;
                    if (half_reg)
                    begin
                        g_reg <= g_reg + 3'd1;
                        if (g_reg == 3'd7)
                        begin
                            if (round_reg == 4'd9)
                                state_reg <= ST_FIN;
                            else
                                round_reg <= round_reg + 4'd1;
                        end
                    end
                end
                ST_FIN:
                begin
                    for (int i = 0; i < 8; i++)
                        cv_out[i] <= cv_in[i] ^ v_reg[i] ^ v_reg[i+8];
                    done      <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/blake2s_hash_engine.sv -----
// blake2s_hash_engine: top level, message buffering, sequencing and digest output.
// Depends on b2s_pkg, b2s_stream_if, b2s_compress.
//
//  channel    dir  payload {fields, lsb first}               handshake
//  msg_in     in   message_word[31:0] valid_bytes[34:32]      valid/ready
//                  final_word[35]
//  dig_out    out  digest_word[31:0] word_index[34:32]        valid/ready
//                  last_result[35]
//  cfg        in   cfg_we, cfg_index[2:0], cfg_data[63:0]      write only
//
// A word that fills nothing is buffered without a compression; a word landing
// on a full block waits for one compression: 10 rounds of 8 G, each in two
// halves, on the shared G unit, one half-G per cycle. A final word adds one
// more compression, then one digest beat per cycle as the sink takes them.
// Reset clears all control state; no clearing pass. msg_in is not ready
// while a compression runs or digest beats are pending.
`default_nettype none
module blake2s_hash_engine (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    b2s_stream_if.sink                   msg_in,
    b2s_stream_if.source                 dig_out,
    input  wire logic                    cfg_we,
    input  wire logic [b2s_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [b2s_pkg::CFG_W-1:0] cfg_data
);
    typedef enum logic [2:0] {ST_IN, ST_CMP, ST_WAIT, ST_OUT} state_t;
    state_t state_reg;

    logic [5:0]  dlen_cfg_reg, klen_cfg_reg;
    logic [63:0] key_reg [4];

    b2s_pkg::word_t cv_reg [8];
    b2s_pkg::word_t buf_reg [16];
    b2s_pkg::word_t cv_new [8];
    logic [63:0] cnt_reg;
    logic [6:0]  nbuf_reg;
    logic        open_reg;
    logic [5:0]  len_reg;
    logic        fin_pend_reg;   // final compress after the current one
    b2s_pkg::word_t pend_word_reg;
    logic [2:0]  pend_n_reg;
    logic        pend_reg;
    logic [2:0]  k_reg;
    b2s_pkg::cmp_req_t req;
    logic        cmp_done;
    logic        out_valid_reg;

    b2s_compress u_cmp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cv_in (cv_reg),
        .msg   (buf_reg),
        .cv_out(cv_new),
        .done  (cmp_done)
    );

    logic [5:0] nn, kk;
    logic [2:0] vb_sat, n_in;
    logic [5:0] rem;
    logic [2:0] last_k;

    always_comb
    begin
        nn = (dlen_cfg_reg == 6'd0) ? 6'd1 : (dlen_cfg_reg > 6'd32 ? 6'd32 : dlen_cfg_reg);
        kk = (klen_cfg_reg > 6'd32) ? 6'd32 : klen_cfg_reg;
        vb_sat = (msg_in.data[34:32] > 3'd4) ? 3'd4 : msg_in.data[34:32];
        n_in = msg_in.data[35] ? vb_sat : 3'd4;
        rem = len_reg - {k_reg, 2'b00};
        last_k = 3'((len_reg - 6'd1) >> 2);
    end

    assign msg_in.ready  = (state_reg == ST_IN);
    assign dig_out.valid = out_valid_reg;
    assign dig_out.data  = {(k_reg == last_k),
                            k_reg,
                            cv_reg[k_reg] & b2s_pkg::byte_mask({1'b0, rem})};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlen_cfg_reg <= 6'd32;
            klen_cfg_reg <= 6'd0;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                b2s_pkg::REG_DIGEST_BYTES: dlen_cfg_reg <= cfg_data[5:0];
                b2s_pkg::REG_KEY_BYTES:    klen_cfg_reg <= cfg_data[5:0];
                b2s_pkg::REG_KEY_WORD_0:   key_reg[0] <= cfg_data;
                b2s_pkg::REG_KEY_WORD_1:   key_reg[1] <= cfg_data;
                b2s_pkg::REG_KEY_WORD_2:   key_reg[2] <= cfg_data;
                b2s_pkg::REG_KEY_WORD_3:   key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IN;
            open_reg      <= 1'b0;
            nbuf_reg      <= '0;
            cnt_reg       <= '0;
            len_reg       <= 6'd32;
            fin_pend_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            req           <= '0;
            for (int i = 0; i < 16; i++) buf_reg[i] <= '0;
            for (int i = 0; i < 8; i++)  cv_reg[i]  <= b2s_pkg::iv_word(3'(i));
        end
        else
        begin
            req.start <= 1'b0;
            unique case (state_reg)
                ST_IN:
                begin
                    if (msg_in.valid)
                    begin
                        logic [6:0] nb;
                        logic [63:0] cnt;
                        b2s_pkg::word_t blk [16];
                        nb  = nbuf_reg;
                        cnt = cnt_reg;
                        for (int i = 0; i < 16; i++)
                            blk[i] = buf_reg[i];
                        if (!open_reg)
                        begin
                            // IV, parameter word folded into word 0
                            for (int i = 0; i < 8; i++)
                                cv_reg[i] <= b2s_pkg::iv_word(3'(i)) ^ ((i == 0) ?
                                    (b2s_pkg::PARAM_BASE | {16'h0, 2'b00, kk, 2'b00, nn})
                                    : 32'h0);
                            len_reg <= nn;
                            cnt = '0;
                            for (int i = 0; i < 16; i++)
                                blk[i] = '0;
                            for (int i = 0; i < 8; i++)
                                blk[i] = (kk != 6'd0)
                                    ? key_reg[i/2][32*(i%2) +: 32] &
                                      b2s_pkg::byte_mask((kk > 6'(4*i)) ?
                                          7'(kk - 6'(4*i)) : 7'd0)
                                    : 32'h0;
                            nb = (kk != 6'd0) ? 7'd64 : 7'd0;
                            open_reg <= 1'b1;
                        end
                        if (n_in != 3'd0 && nb >= 7'd64)
                        begin
                            // compress full block first, then place the word
                            cnt = cnt + 64'd64;
                            pend_reg      <= 1'b1;
                            pend_word_reg <= msg_in.data[31:0] &
                                             b2s_pkg::byte_mask({4'd0, n_in});
                            pend_n_reg    <= n_in;
                            fin_pend_reg  <= msg_in.data[35];
                            req.start     <= 1'b1;
                            req.last      <= 1'b0;
                            req.counter   <= cnt;
                            nbuf_reg      <= nb;
                            state_reg     <= ST_CMP;
                        end
                        else
                        begin
                            if (n_in != 3'd0)
                            begin
                                blk[nb[5:2]] = msg_in.data[31:0] &
                                               b2s_pkg::byte_mask({4'd0, n_in});
                                nb = nb + 7'(n_in);
                            end
                            nbuf_reg <= nb;
                            if (msg_in.data[35])
                            begin
                                cnt = cnt + 64'(nb);
                                req.start   <= 1'b1;
                                req.last    <= 1'b1;
                                req.counter <= cnt;
                                fin_pend_reg <= 1'b0;
                                state_reg   <= ST_CMP;
                            end
                        end
                        for (int i = 0; i < 16; i++)
                            buf_reg[i] <= blk[i];
                        cnt_reg <= cnt;
                    end
                end
                ST_CMP:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (cmp_done)
                    begin
                        for (int i = 0; i < 8; i++) cv_reg[i] <= cv_new[i];
                        if (pend_reg)
                        begin
                            logic [63:0] cnt;
                            for (int i = 1; i < 16; i++) buf_reg[i] <= '0;
                            buf_reg[0] <= pend_word_reg;
                            nbuf_reg   <= 7'(pend_n_reg);
                            pend_reg   <= 1'b0;
                            if (fin_pend_reg)
                            begin
                                cnt = cnt_reg + 64'(pend_n_reg);
                                cnt_reg     <= cnt;
                                req.start   <= 1'b1;
                                req.last    <= 1'b1;
                                req.counter <= cnt;
                                fin_pend_reg <= 1'b0;
                                state_reg   <= ST_CMP;
                            end
                            else
                                state_reg <= ST_IN;
                        end
                        else
                        begin
                            open_reg      <= 1'b0;
                            k_reg         <= '0;
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (dig_out.ready)
                    begin
                        if (k_reg == last_k)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= ST_IN;
                        end
                        else
                            k_reg <= k_reg + 3'd1;
                    end
                end
                default: state_reg <= ST_IN;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/b2s_checker.sv -----
// b2s_checker: port-level assertions for blake2s_hash_engine, with bind.
// Depends on b2s_stream_if, blake2s_hash_engine.
`default_nettype none
module b2s_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [35:0] in_data,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [35:0] out_data
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready during digest beats");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("digest beat changed while stalled");
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data[35] |=> out_valid &&
        out_data[34:32] == $past(out_data[34:32]) + 3'd1)
        else $error("digest index did not advance");
    a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> out_data[34:32] == 3'd0)
        else $error("digest does not start at word 0");
    a_nonfinal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data[35] |=> !out_valid)
        else $error("result on a non-final word");
endmodule

bind blake2s_hash_engine b2s_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(msg_in.valid), .in_ready(msg_in.ready), .in_data(msg_in.data),
    .out_valid(dig_out.valid), .out_ready(dig_out.ready), .out_data(dig_out.data)
);
`default_nettype wire
